// ===== rtl/wad_pkg.sv =====
// Shared types and constants for the windowed activity detector.
// No dependencies; the front end, back end, top level and testbench import this package.
package wad_pkg;

    localparam int TIME_W    = 32;
    localparam int THR_W     = 5;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CMDQ_DEPTH = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH = 1'd1;

    localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd1000;
    localparam logic [THR_W-1:0]  THRESH_RESET = 5'd3;

    // Input item kinds
    localparam logic ACT_SAMPLE  = 1'b0;
    localparam logic ACT_ANALYZE = 1'b1;

    // Command passed from the front end to the back end
    typedef struct packed {
        logic              analyze;
        logic [TIME_W-1:0] now_ms;
    } cmd_t;

    // Handshake between front and back
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_chan_t;

endpackage

// ===== rtl/wad_front.sv =====
// Front end: accepts input items, drops inactive samples, queues commands.
// Depends on wad_pkg.
module wad_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       action,
    input  logic                       pin_active,
    input  logic [wad_pkg::TIME_W-1:0] now_ms,
    output wad_pkg::cmd_chan_t         chan,
    input  logic                       cmd_ready
);
    import wad_pkg::*;

    localparam int PTR_W = $clog2(CMDQ_DEPTH);
    localparam int LVL_W = $clog2(CMDQ_DEPTH + 1);

    cmd_t               entries_reg [CMDQ_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [LVL_W-1:0]   level_reg;
    logic [LVL_W-1:0]   level_next;
    logic               keep;
    logic               do_push;
    logic               do_pop;

    assign full    = (level_reg == LVL_W'(CMDQ_DEPTH));
    assign keep    = (action == ACT_ANALYZE) || pin_active;
    assign do_push = push && !full && keep;
    assign do_pop  = chan.valid && cmd_ready;

    assign chan.valid = (level_reg != '0);
    assign chan.cmd   = entries_reg[rd_ptr_reg];

    always_comb
    begin
        level_next = level_reg;
        if (do_push && !do_pop)
        begin
            level_next = level_reg + LVL_W'(1);
        end
        else if (!do_push && do_pop)
        begin
            level_next = level_reg - LVL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            level_reg <= level_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(CMDQ_DEPTH - 1)) ? '0
                              : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(CMDQ_DEPTH - 1)) ? '0
                              : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg].analyze <= (action == ACT_ANALYZE);
            entries_reg[wr_ptr_reg].now_ms  <= now_ms;
        end
    end

endmodule

// ===== rtl/wad_back.sv =====
// Back end: timestamp ring, window walk, config registers and result slot.
// Depends on wad_pkg.
module wad_back #(
    parameter int RING_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wad_pkg::cmd_chan_t            chan,
    output logic                          cmd_ready,
    input  logic                          cfg_we,
    input  logic [wad_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wad_pkg::CFG_W-1:0]     cfg_data,
    output logic                          empty,
    input  logic                          pop,
    output logic                          detected,
    output logic                          went_active,
    output logic                          went_inactive
);
    import wad_pkg::*;

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_CMP  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    logic [TIME_W-1:0] ring_mem [RING_DEPTH];
    logic [TIME_W-1:0] rd_data_reg;

    state_t            state_reg, state_next;
    logic [TIME_W-1:0] window_reg;
    logic [THR_W-1:0]  thresh_reg;
    logic [PTR_W-1:0]  wr_pos_reg;
    logic [CNT_W-1:0]  filled_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [THR_W-1:0]  count_reg;
    logic [TIME_W-1:0] now_reg;
    logic              active_reg;
    logic              out_valid_reg;
    logic              out_det_reg;
    logic              out_rise_reg;
    logic              out_fall_reg;

    logic              take;
    logic              do_store;
    logic              do_start;
    logic [TIME_W-1:0] age;
    logic              in_win;
    logic [THR_W-1:0]  count_inc;
    logic [CNT_W-1:0]  idx_inc;
    logic              walk_done;
    logic              det_now;
    logic [PTR_W-1:0]  newest;
    logic [PTR_W-1:0]  rd_ptr_dec;

    // An analysis needs the result slot free; it stays free until the walk ends.
    assign cmd_ready = (state_reg == S_IDLE) && (!chan.cmd.analyze || !out_valid_reg);
    assign take      = chan.valid && cmd_ready;
    assign do_store  = take && !chan.cmd.analyze;
    assign do_start  = take && chan.cmd.analyze;

    assign newest     = (wr_pos_reg == '0) ? PTR_W'(RING_DEPTH - 1) : wr_pos_reg - PTR_W'(1);
    assign rd_ptr_dec = (rd_ptr_reg == '0) ? PTR_W'(RING_DEPTH - 1) : rd_ptr_reg - PTR_W'(1);

    assign age       = now_reg - rd_data_reg;
    assign in_win    = (age <= window_reg);
    assign count_inc = count_reg + THR_W'(1);
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign walk_done = (count_inc >= thresh_reg) || (idx_inc >= filled_reg);
    assign det_now   = (count_reg >= thresh_reg);

    assign empty         = !out_valid_reg;
    assign detected      = out_det_reg;
    assign went_active   = out_rise_reg;
    assign went_inactive = out_fall_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (do_start)
                begin
                    // Empty ring or zero threshold: nothing to walk
                    state_next = ((filled_reg == '0) || (thresh_reg == '0)) ? S_FIN : S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = (!in_win || walk_done) ? S_FIN : S_RD;
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            window_reg    <= WINDOW_RESET;
            thresh_reg    <= THRESH_RESET;
            wr_pos_reg    <= '0;
            filled_reg    <= '0;
            rd_ptr_reg    <= '0;
            idx_reg       <= '0;
            count_reg     <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WINDOW: window_reg <= cfg_data;
                    REG_THRESH: thresh_reg <= cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end

            if (do_store)
            begin
                wr_pos_reg <= (wr_pos_reg == PTR_W'(RING_DEPTH - 1)) ? '0
                              : wr_pos_reg + PTR_W'(1);
                if (filled_reg != CNT_W'(RING_DEPTH))
                begin
                    filled_reg <= filled_reg + CNT_W'(1);
                end
            end

            if (do_start)
            begin
                rd_ptr_reg <= newest;
                idx_reg    <= '0;
                count_reg  <= '0;
            end

            if ((state_reg == S_CMP) && in_win)
            begin
                count_reg  <= count_inc;
                idx_reg    <= idx_inc;
                rd_ptr_reg <= rd_ptr_dec;
            end

            if (state_reg == S_FIN)
            begin
                active_reg    <= det_now;
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Ring storage and payload registers
    always_ff @(posedge clk)
    begin
        if (do_store)
        begin
            ring_mem[wr_pos_reg] <= chan.cmd.now_ms;
        end
        if (state_reg == S_RD)
        begin
            rd_data_reg <= ring_mem[rd_ptr_reg];
        end
        if (do_start)
        begin
            now_reg <= chan.cmd.now_ms;
        end
        if (state_reg == S_FIN)
        begin
            out_det_reg  <= det_now;
            out_rise_reg <= det_now && !active_reg;
            out_fall_reg <= !det_now && active_reg;
        end
    end

endmodule

// ===== rtl/windowed_activity_detector_top.sv =====
// Top level of the windowed activity detector: front end, command queue, back end.
// Depends on wad_pkg, wad_front and wad_back.
//
//   channel  | handshake      | payload
//   ---------+----------------+------------------------------------------
//   input    | push / full    | action, pin_active, now_ms
//   result   | empty / pop    | detected, went_active, went_inactive
//   config   | cfg_we         | cfg_index, cfg_data
//
// A stored sample is written into the ring when the back end takes it; inactive samples are dropped at the front.
// An analysis walks the ring from the newest entry, at most RING_DEPTH entries, and stops at a stale
// entry, at the threshold or at the oldest entry; each step is one ring memory read and compare.
// The front queue holds two commands, so items are accepted while a walk runs.
// An analysis waits while the single result slot is still full.
// Reset clears pointers, fill count and state; ring contents are not cleared.
module windowed_activity_detector_top #(
    parameter int RING_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          action,
    input  logic                          pin_active,
    input  logic [wad_pkg::TIME_W-1:0]    now_ms,
    output logic                          empty,
    input  logic                          pop,
    output logic                          detected,
    output logic                          went_active,
    output logic                          went_inactive,
    input  logic                          cfg_we,
    input  logic [wad_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wad_pkg::CFG_W-1:0]     cfg_data
);
    import wad_pkg::*;

    cmd_chan_t chan;
    logic      cmd_ready;

    wad_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .action     (action),
        .pin_active (pin_active),
        .now_ms     (now_ms),
        .chan       (chan),
        .cmd_ready  (cmd_ready)
    );

    wad_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .chan          (chan),
        .cmd_ready     (cmd_ready),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .empty         (empty),
        .pop           (pop),
        .detected      (detected),
        .went_active   (went_active),
        .went_inactive (went_inactive)
    );

endmodule

// ===== rtl/wad_checker.sv =====
// Port-level checks for the windowed activity detector, bound to the top level.
// Depends on windowed_activity_detector_top.
module wad_checker (
    input logic clk,
    input logic rst_n,
    input logic empty,
    input logic pop,
    input logic detected,
    input logic went_active,
    input logic went_inactive
);

    // Single result slot: a taken result leaves it empty in the next cycle
    a_pop_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty) |=> empty)
        else $error("result slot not empty after pop");

    a_rise_means_active: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && went_active) |-> (detected && !went_inactive))
        else $error("went_active without detected");

    a_fall_means_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && went_inactive) |-> !detected)
        else $error("went_inactive with detected");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(detected) && $stable(went_active)))
        else $error("waiting result changed");

endmodule

bind windowed_activity_detector_top wad_checker u_wad_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .detected      (detected),
    .went_active   (went_active),
    .went_inactive (went_inactive)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for windowed_activity_detector_top.
// Depends on wad_pkg and the detector RTL; keeps its own copy of the timestamp ring
// to predict each analysis verdict.
`timescale 1ns / 1ps

module tb_top;

    import wad_pkg::*;

    localparam int RING_DEPTH    = 16;
    // settle time after a pause: an analysis walk may still run and two more commands may be queued
    localparam int SETTLE_CYCLES = 128;
    localparam int MAX_PRINTED   = 50;

    typedef struct packed {
        logic detected;
        logic went_active;
        logic went_inactive;
    } verdict_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 push          = 1'b0;
    logic                 full;
    logic                 action        = ACT_SAMPLE;
    logic                 pin_active    = 1'b0;
    logic [TIME_W-1:0]    now_ms        = '0;
    logic                 empty;
    logic                 pop           = 1'b0;
    logic                 detected;
    logic                 went_active;
    logic                 went_inactive;
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = REG_WINDOW;
    logic [CFG_W-1:0]     cfg_data      = '0;

    // predictor state
    logic [TIME_W-1:0] stamp_copy [RING_DEPTH];
    logic [3:0]        next_slot     = '0;
    logic [4:0]        stamp_count   = '0;
    logic              state_active  = 1'b0;
    logic [TIME_W-1:0] cur_window    = WINDOW_RESET;
    logic [THR_W-1:0]  cur_threshold = THRESH_RESET;

    verdict_t          expected_verdicts [$];
    int                mismatch_count = 0;
    int                send_idle_pct  = 0;
    int                pop_stall_pct  = 0;
    logic [TIME_W-1:0] sim_clock_ms;

    windowed_activity_detector_top #(
        .RING_DEPTH(RING_DEPTH)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .action       (action),
        .pin_active   (pin_active),
        .now_ms       (now_ms),
        .empty        (empty),
        .pop          (pop),
        .detected     (detected),
        .went_active  (went_active),
        .went_inactive(went_inactive),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Walk from the newest stamp backward, stop at the first stale one or at threshold.
    function automatic logic [4:0] count_recent_stamps(input logic [TIME_W-1:0] t);
        logic [4:0]        hits;
        logic [3:0]        slot;
        logic [TIME_W-1:0] age;
        logic              done;
        int                i;
        hits = '0;
        done = 1'b0;
        for (i = 0; i < stamp_count; i++)
        begin
            if (!done)
            begin
                slot = next_slot - 4'(i) - 4'd1;
                age  = t - stamp_copy[slot];
                if (age > cur_window)
                    done = 1'b1;
                else
                begin
                    hits++;
                    if (hits >= cur_threshold)
                        done = 1'b1;
                end
            end
        end
        return hits;
    endfunction

    function automatic void track_item(input logic act, input logic pin,
                                       input logic [TIME_W-1:0] t);
        verdict_t v;
        logic     hit;
        if (act == ACT_SAMPLE)
        begin
            if (pin)
            begin
                stamp_copy[next_slot] = t;
                next_slot = next_slot + 4'd1;
                if (stamp_count < RING_DEPTH)
                    stamp_count = stamp_count + 5'd1;
            end
        end
        else
        begin
            hit             = (count_recent_stamps(t) >= cur_threshold);
            v.detected      = hit;
            v.went_active   = hit && !state_active;
            v.went_inactive = !hit && state_active;
            state_active    = hit;
            expected_verdicts.push_back(v);
        end
    endfunction

    // accepted items feed the predictor
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
            track_item(action, pin_active, now_ms);
    end

    always @(posedge clk)
    begin
        pop <= ($urandom_range(0, 99) >= pop_stall_pct);
    end

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_verdicts.size() == 0)
                report_mismatch("verdict with no analysis pending");
            else
            begin
                want = expected_verdicts.pop_front();
                if (detected !== want.detected)
                    report_mismatch($sformatf("detected %b, want %b",
                                              detected, want.detected));
                if (went_active !== want.went_active)
                    report_mismatch($sformatf("went_active %b, want %b",
                                              went_active, want.went_active));
                if (went_inactive !== want.went_inactive)
                    report_mismatch($sformatf("went_inactive %b, want %b",
                                              went_inactive, want.went_inactive));
            end
        end
    end

    task automatic send_item(input logic act, input logic pin, input logic [TIME_W-1:0] t);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        action     <= act;
        pin_active <= pin;
        now_ms     <= t;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic pause_sender();
        push <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_verdicts_drained();
        while (expected_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // Only written with the detector idle: no verdict owed and no sample still queued.
    task automatic write_config(input logic [TIME_W-1:0] win, input logic [THR_W-1:0] thr);
        logic [31:0] junk;
        junk = $urandom();
        pause_sender();
        wait_verdicts_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_WINDOW;
        cfg_data  <= win;
        @(posedge clk);
        cfg_index <= REG_THRESH;
        cfg_data  <= {junk[31:THR_W], thr};  // upper bits are don't-care
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_window    = win;
        cur_threshold = thr;
    endtask

    task automatic test_empty_ring();
        send_item(ACT_ANALYZE, 1'b0, 32'd0);
        // threshold zero reports active even with nothing stored
        write_config(32'd1000, 5'd0);
        send_item(ACT_ANALYZE, 1'b1, 32'hFFFF_FFFF);
        write_config(WINDOW_RESET, THRESH_RESET);
        send_item(ACT_ANALYZE, 1'b0, 32'd5);
    endtask

    task automatic test_window_edge();
        send_item(ACT_SAMPLE, 1'b0, 32'd100);
        send_item(ACT_SAMPLE, 1'b1, 32'd100);
        send_item(ACT_SAMPLE, 1'b1, 32'd200);
        send_item(ACT_SAMPLE, 1'b1, 32'd300);
        send_item(ACT_ANALYZE, 1'b0, 32'd300);
        // oldest age 1100 is past the window, age exactly 1000 still counts
        send_item(ACT_ANALYZE, 1'b1, 32'd1200);
    endtask

    task automatic test_time_wrap();
        send_item(ACT_SAMPLE, 1'b1, 32'hFFFF_FF00);
        send_item(ACT_SAMPLE, 1'b1, 32'hFFFF_FFF0);
        send_item(ACT_SAMPLE, 1'b1, 32'hFFFF_FFFF);
        send_item(ACT_ANALYZE, 1'b0, 32'h0000_0100);
        // newest stamp lies in the future, so it reads as very old
        send_item(ACT_ANALYZE, 1'b0, 32'hFFFF_FF80);
    endtask

    task automatic test_ring_full();
        int i;
        write_config(32'hFFFF_FFFF, 5'd16);
        for (i = 0; i < RING_DEPTH - 5; i++)
            send_item(ACT_SAMPLE, 1'b1, 32'h5A5A_0000 + 32'(i));
        send_item(ACT_ANALYZE, 1'b0, 32'hA5A5_A5A5);
        write_config(32'hFFFF_FFFF, 5'd17);
        send_item(ACT_ANALYZE, 1'b1, 32'h0000_0000);
    endtask

    task automatic test_random_block(input int n, input logic [TIME_W-1:0] win,
                                     input logic [THR_W-1:0] thr,
                                     input int idle_pct, input int stall_pct);
        int                counted;
        int                pick;
        logic [TIME_W-1:0] step_max;
        logic              act;
        logic              pin;
        counted  = 0;
        step_max = (thr > 1) ? win / thr : win >> 1;
        if (step_max == 0)
            step_max = 1;
        write_config(win, thr);
        send_idle_pct = idle_pct;
        pop_stall_pct = stall_pct;
        while (counted < n)
        begin
            if ($urandom_range(0, 19) == 0)
                sim_clock_ms = sim_clock_ms + $urandom();
            else
                sim_clock_ms = sim_clock_ms + $urandom_range(0, step_max);
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                act = ACT_SAMPLE;
                pin = 1'b1;
            end
            else if (pick < 60)
            begin
                act = ACT_SAMPLE;
                pin = 1'b0;
            end
            else if (pick < 95)
            begin
                act = ACT_ANALYZE;
                pin = 1'($urandom_range(0, 1));
            end
            else
            begin
                act = 1'($urandom_range(0, 1));
                pin = 1'($urandom_range(0, 1));
            end
            if (pick >= 95)
                send_item(act, pin, $urandom());
            else
                send_item(act, pin, sim_clock_ms);
            counted++;
            // hold off once per block until every verdict is back
            if (counted == n / 2)
            begin
                pause_sender();
                wait_verdicts_drained();
            end
        end
        send_idle_pct = 0;
        pop_stall_pct = 0;
    endtask

    initial
    begin
        sim_clock_ms = $urandom();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_ring();
        test_window_edge();
        test_time_wrap();
        test_ring_full();

        test_random_block(100, WINDOW_RESET, THRESH_RESET, 0, 0);
        test_random_block(100, 32'd20, 5'd16, 0, 0);
        test_random_block(100, 32'hFFFF_FFFF, 5'd31, 64, 0);
        test_random_block(100, 32'd0, 5'd1, 64, 0);
        test_random_block(100, $urandom(), 5'($urandom_range(0, 31)), 0, 64);
        test_random_block(100, 32'd500, 5'd8, 0, 64);
        test_random_block(100, 32'hFFFF_FFFF, 5'd16, 7, 7);
        test_random_block(100, 32'($urandom_range(1, 5000)), 5'd2, 7, 7);

        pause_sender();
        wait_verdicts_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_verdicts.size() != 0)
            report_mismatch("analysis verdicts never delivered");

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
